// File: hw/rtl/scpp_pkg.sv
// ============================================================================
// Sparse column pad packer package
// Shared constants, operation codes and the queue entry type.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package scpp_pkg;

    localparam int GROUP_SIZE  = 4;
    localparam int PTR_W       = 20;
    localparam int PAD_W       = PTR_W + 1;
    localparam int ROW_W       = 16;
    localparam int VALUE_W     = 64;
    localparam int COL_W       = 16;
    localparam int CFG_W       = 16;
    localparam int FILL_W      = $clog2(GROUP_SIZE);
    localparam int CNT_W       = $clog2(GROUP_SIZE + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_POINTER = 2'd0;
    localparam logic [1:0] MODE_ELEMENT = 2'd1;
    localparam logic [1:0] MODE_FINISH  = 2'd2;

    localparam logic [0:0] REG_NUM_COLS = 1'd0;
    localparam logic [0:0] REG_NUM_ROWS = 1'd1;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_GROUP  = 1'b1;

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_GROUP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t                                  op;
        logic [PTR_W-1:0]                     len;
        logic [CNT_W-1:0]                     cnt;
        logic [GROUP_SIZE-1:0][VALUE_W-1:0]   values;
        logic [GROUP_SIZE-1:0][ROW_W-1:0]     rows;
    } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/scpp_front.sv
// ============================================================================
// Sparse column pad packer front end
// Accepts items, tracks column state and queues records, groups and finishes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scpp_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    mode,
    input  wire logic [scpp_pkg::PTR_W-1:0]    col_pointer,
    input  wire logic [scpp_pkg::VALUE_W-1:0]  elem_value,
    input  wire logic [scpp_pkg::ROW_W-1:0]    elem_row,
    input  wire logic [scpp_pkg::COL_W-1:0]    num_cols,
    input  wire logic                          q_full,
    output logic                               q_push,
    output scpp_pkg::entry_t                   q_entry
);
    import scpp_pkg::*;

    logic [PTR_W-1:0]   prev_pointer_reg;
    logic [PTR_W-1:0]   prev_pointer_next;
    logic               pointer_seen_reg;
    logic               pointer_seen_next;
    logic [PTR_W-1:0]   remaining_reg;
    logic [PTR_W-1:0]   remaining_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [COL_W-1:0]   cols_reg;
    logic [COL_W-1:0]   cols_next;
    logic [VALUE_W-1:0] slot_values_reg [GROUP_SIZE];
    logic [ROW_W-1:0]   slot_rows_reg   [GROUP_SIZE];

    logic               accept;
    logic               slot_write;
    logic [PTR_W-1:0]   length;
    logic [COL_W:0]     limit;
    logic [COL_W:0]     due;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign length = col_pointer - prev_pointer_reg;
    assign limit  = (COL_W+1)'(num_cols) + (COL_W+1)'(GROUP_SIZE)
                    - (COL_W+1)'(num_cols[FILL_W-1:0]);
    assign due    = limit - (COL_W+1)'(cols_reg);

    always_comb
    begin
        prev_pointer_next = prev_pointer_reg;
        pointer_seen_next = pointer_seen_reg;
        remaining_next    = remaining_reg;
        fill_next         = fill_reg;
        cols_next         = cols_reg;
        slot_write        = 1'b0;
        q_push            = 1'b0;
        q_entry.op        = OP_RECORD;
        q_entry.len       = length;
        q_entry.cnt       = CNT_W'(fill_reg) + CNT_W'(1);
        for (int j = 0; j < GROUP_SIZE; j++)
        begin
            q_entry.values[j] = (FILL_W'(j) == fill_reg) ? elem_value : slot_values_reg[j];
            q_entry.rows[j]   = (FILL_W'(j) == fill_reg) ? elem_row : slot_rows_reg[j];
        end
        if (accept)
        begin
            unique case (mode)
                MODE_POINTER:
                begin
                    if (!pointer_seen_reg)
                    begin
                        prev_pointer_next = col_pointer;
                        pointer_seen_next = 1'b1;
                    end
                    else if (cols_reg < num_cols)
                    begin
                        prev_pointer_next = col_pointer;
                        remaining_next    = length;
                        fill_next         = '0;
                        cols_next         = cols_reg + COL_W'(1);
                        q_push            = 1'b1;
                    end
                end
                MODE_ELEMENT:
                begin
                    if (remaining_reg != '0)
                    begin
                        slot_write     = 1'b1;
                        remaining_next = remaining_reg - PTR_W'(1);
                        fill_next      = fill_reg + FILL_W'(1);
                        if (fill_reg == FILL_W'(GROUP_SIZE - 1) || remaining_reg == PTR_W'(1))
                        begin
                            fill_next  = '0;
                            q_push     = 1'b1;
                            q_entry.op = OP_GROUP;
                        end
                    end
                end
                MODE_FINISH:
                begin
                    prev_pointer_next = '0;
                    pointer_seen_next = 1'b0;
                    remaining_next    = '0;
                    fill_next         = '0;
                    cols_next         = '0;
                    q_entry.op        = OP_FINISH;
                    if ((COL_W+1)'(cols_reg) < limit)
                    begin
                        q_push      = 1'b1;
                        q_entry.cnt = (due > (COL_W+1)'(GROUP_SIZE)) ? CNT_W'(GROUP_SIZE)
                                                                     : due[CNT_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pointer_reg <= '0;
            pointer_seen_reg <= 1'b0;
            remaining_reg    <= '0;
            fill_reg         <= '0;
            cols_reg         <= '0;
        end
        else
        begin
            prev_pointer_reg <= prev_pointer_next;
            pointer_seen_reg <= pointer_seen_next;
            remaining_reg    <= remaining_next;
            fill_reg         <= fill_next;
            cols_reg         <= cols_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_write)
        begin
            slot_values_reg[fill_reg] <= elem_value;
            slot_rows_reg[fill_reg]   <= elem_row;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/scpp_queue.sv
// ============================================================================
// Sparse column pad packer queue
// Short first-in first-out buffer between the front and back ends.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scpp_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_push,
    input  wire scpp_pkg::entry_t  q_wdata,
    output logic                   q_full,
    input  wire logic              q_pop,
    output logic                   q_empty,
    output scpp_pkg::entry_t       q_rdata
);
    import scpp_pkg::*;

    entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_rdata = mem[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wdata;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/scpp_back.sv
// ============================================================================
// Sparse column pad packer back end
// Expands queued operations into result items and holds them for the receiver.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scpp_back
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      q_empty,
    input  wire scpp_pkg::entry_t                          q_rdata,
    output logic                                           q_pop,
    input  wire logic [scpp_pkg::ROW_W-1:0]                num_rows,
    output logic                                           empty,
    input  wire logic                                      pop,
    output logic                                           kind,
    output logic [scpp_pkg::PTR_W-1:0]                     col_length,
    output logic [scpp_pkg::PAD_W-1:0]                     col_length_padded,
    output logic [scpp_pkg::GROUP_SIZE-1:0][scpp_pkg::VALUE_W-1:0] values,
    output logic [scpp_pkg::GROUP_SIZE-1:0][scpp_pkg::ROW_W-1:0]   rows,
    output logic                                           last
);
    import scpp_pkg::*;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [CNT_W-1:0]                   sub_reg;
    logic [CNT_W-1:0]                   sub_next;
    logic                               kind_reg;
    logic [PTR_W-1:0]                   len_reg;
    logic [PAD_W-1:0]                   padded_reg;
    logic [GROUP_SIZE-1:0][VALUE_W-1:0] values_reg;
    logic [GROUP_SIZE-1:0][ROW_W-1:0]   rows_reg;
    logic                               last_reg;

    logic                               load;
    logic                               kind_d;
    logic [PTR_W-1:0]                   len_d;
    logic [PAD_W-1:0]                   padded_d;
    logic [PAD_W-1:0]                   round_up;
    logic [GROUP_SIZE-1:0][VALUE_W-1:0] values_d;
    logic [GROUP_SIZE-1:0][ROW_W-1:0]   rows_d;
    logic                               last_d;

    assign load     = !q_empty && (!out_valid_reg || pop);
    assign round_up = PAD_W'(q_rdata.len) + PAD_W'(GROUP_SIZE - 1);

    always_comb
    begin
        kind_d   = KIND_RECORD;
        len_d    = '0;
        padded_d = '0;
        values_d = '0;
        rows_d   = '0;
        last_d   = 1'b1;
        q_pop    = 1'b0;
        sub_next = sub_reg;
        if (load)
        begin
            unique case (q_rdata.op)
                OP_RECORD:
                begin
                    len_d    = q_rdata.len;
                    padded_d = round_up & ~PAD_W'(GROUP_SIZE - 1);
                    q_pop    = 1'b1;
                end
                OP_GROUP:
                begin
                    kind_d = KIND_GROUP;
                    for (int j = 0; j < GROUP_SIZE; j++)
                    begin
                        if (CNT_W'(j) < q_rdata.cnt)
                        begin
                            values_d[j] = q_rdata.values[j];
                            rows_d[j]   = q_rdata.rows[j];
                        end
                        else
                        begin
                            rows_d[j] = num_rows + ROW_W'(j);
                        end
                    end
                    q_pop = 1'b1;
                end
                OP_FINISH:
                begin
                    last_d = (sub_reg + CNT_W'(1) == q_rdata.cnt);
                    if (last_d)
                    begin
                        q_pop    = 1'b1;
                        sub_next = '0;
                    end
                    else
                    begin
                        sub_next = sub_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_d;
            len_reg    <= len_d;
            padded_reg <= padded_d;
            values_reg <= values_d;
            rows_reg   <= rows_d;
            last_reg   <= last_d;
        end
    end

    assign empty             = !out_valid_reg;
    assign kind              = kind_reg;
    assign col_length        = len_reg;
    assign col_length_padded = padded_reg;
    assign values            = values_reg;
    assign rows              = rows_reg;
    assign last              = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sparse_column_pad_packer.sv
// ============================================================================
// Sparse column pad packer
// Reformats a compressed-sparse-column stream into column records and
// padded groups of four nonzeros.
//
// Input items enter through push/full with a mode field: column pointer,
// nonzero element or finish. An item is taken on a clock edge where push
// is high and full is low. Results leave through empty/pop; the oldest
// result sits on the output ports while empty is low and is taken on an
// edge where pop is high. Registers num_cols and num_rows are written
// through write_en, reg_index and write_data; the user must write them
// only while the block idles, as the block itself does not enforce it.
// A new item can be taken every cycle while full is low. A result passes
// through the queue and is then loaded into the output register. A finish
// item makes up to four records, and the back end emits them one at a time,
// so the two-entry queue between front and back fills and full rises while
// they drain. When the receiver holds pop low, the output register and the
// queue fill and full is raised; nothing is lost. Reset clears the column
// state, empties the queue and sets both registers to one.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sparse_column_pad_packer
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [1:0]                      mode,
    input  wire logic [scpp_pkg::PTR_W-1:0]      col_pointer,
    input  wire logic [scpp_pkg::VALUE_W-1:0]    elem_value,
    input  wire logic [scpp_pkg::ROW_W-1:0]      elem_row,
    input  wire logic                            write_en,
    input  wire logic [0:0]                      reg_index,
    input  wire logic [scpp_pkg::CFG_W-1:0]      write_data,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 kind,
    output logic [scpp_pkg::PTR_W-1:0]           col_length,
    output logic [scpp_pkg::PAD_W-1:0]           col_length_padded,
    output logic [scpp_pkg::VALUE_W-1:0]         value_0,
    output logic [scpp_pkg::VALUE_W-1:0]         value_1,
    output logic [scpp_pkg::VALUE_W-1:0]         value_2,
    output logic [scpp_pkg::VALUE_W-1:0]         value_3,
    output logic [scpp_pkg::ROW_W-1:0]           row_0,
    output logic [scpp_pkg::ROW_W-1:0]           row_1,
    output logic [scpp_pkg::ROW_W-1:0]           row_2,
    output logic [scpp_pkg::ROW_W-1:0]           row_3,
    output logic                                 last
);
    import scpp_pkg::*;

    logic [COL_W-1:0]                   num_cols_reg;
    logic [COL_W-1:0]                   num_cols_next;
    logic [ROW_W-1:0]                   num_rows_reg;
    logic [ROW_W-1:0]                   num_rows_next;

    logic                               q_push;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_empty;
    entry_t                             q_wdata;
    entry_t                             q_rdata;
    logic [GROUP_SIZE-1:0][VALUE_W-1:0] values;
    logic [GROUP_SIZE-1:0][ROW_W-1:0]   rows;

    always_comb
    begin
        num_cols_next = num_cols_reg;
        num_rows_next = num_rows_reg;
        if (write_en)
        begin
            unique case (reg_index)
                REG_NUM_COLS: num_cols_next = COL_W'(write_data);
                REG_NUM_ROWS: num_rows_next = ROW_W'(write_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= COL_W'(1);
            num_rows_reg <= ROW_W'(1);
        end
        else
        begin
            num_cols_reg <= num_cols_next;
            num_rows_reg <= num_rows_next;
        end
    end

    scpp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .col_pointer (col_pointer),
        .elem_value  (elem_value),
        .elem_row    (elem_row),
        .num_cols    (num_cols_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_wdata)
    );

    scpp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_rdata (q_rdata)
    );

    scpp_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_rdata           (q_rdata),
        .q_pop             (q_pop),
        .num_rows          (num_rows_reg),
        .empty             (empty),
        .pop               (pop),
        .kind              (kind),
        .col_length        (col_length),
        .col_length_padded (col_length_padded),
        .values            (values),
        .rows              (rows),
        .last              (last)
    );

    assign value_0 = values[0];
    assign value_1 = values[1];
    assign value_2 = values[2];
    assign value_3 = values[3];
    assign row_0   = rows[0];
    assign row_1   = rows[1];
    assign row_2   = rows[2];
    assign row_3   = rows[3];

endmodule

`default_nettype wire
